>>> rtl/fqs_pkg.sv
// fqs_pkg: command and result words, command and status codes for the
// fifo queue with search core
// no dependencies
package fqs_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned OCC_W  = 7;
  localparam int unsigned DATA_W = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DISPLAY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STATUS  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOCATE  = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_ENTRY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] entry_value;
    logic [OCC_W-1:0]         occupancy;
    logic                     last;
  } res_t;

endpackage

>>> rtl/fifo_queue_with_search_core.sv
// fifo_queue_with_search_core: bounded fifo of signed 32-bit values with
// display and linear search, one command word at a time
// depends on fqs_pkg
//
// usage
//   command channel: a word (req_i) is taken at a rising edge where start
//   is high and busy is low. insert, remove and status never raise busy,
//   so such commands can follow in every cycle.
//   result channel: res_valid_o marks a result word on res_o for exactly
//   one cycle; the receiver cannot stall it. res_o.last flags the final
//   word caused by a command. insert of zero into a queue that is not
//   full and unused command codes give no result at all.
//   a command that leaves busy low shows its result in the cycle after it
//   is taken. display walks the stored entries through the entry memory,
//   one read a cycle with registered read data, and each entry word is
//   registered once more into res_o. locate walks the same way and adds a
//   finish state to close the match list (the last match is held back so
//   it can carry last). busy stays high for the whole walk, so no new
//   command is taken until it ends; its length is set by the single read
//   port of the entry memory.
//   reset: head and count clear, the queue is empty. the entry memory is
//   not cleared; only written slots are ever read.
module fifo_queue_with_search_core
  import fqs_pkg::*;
#(
  parameter int unsigned DEPTH = 64  // 1 to 64, bounded by the position field
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,  // issue one memory read per cycle
    S_DRAIN  = 4'b0100,  // last read data comes back
    S_FINISH = 4'b1000   // locate: flush held match or report not found
  } state_e;

  // head plus offset, wrapped at the queue depth
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [OCC_W-1:0] k);
    logic [OCC_W:0] s;
    s = (OCC_W+1)'(head) + (OCC_W+1)'(k);
    if (s >= (OCC_W+1)'(DEPTH)) s = s - (OCC_W+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic res_t mk_res(input logic [STAT_W-1:0] st,
                                  input logic [POS_W-1:0] pos,
                                  input logic [DATA_W-1:0] val,
                                  input logic [OCC_W-1:0] occ,
                                  input logic lst);
    res_t r;
    r.status      = st;
    r.position    = pos;
    r.entry_value = val;
    r.occupancy   = occ;
    r.last        = lst;
    return r;
  endfunction

  // control state
  state_e           state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [OCC_W-1:0] count_q, count_d;
  logic [OCC_W-1:0] k_q, k_d;          // next offset to read
  logic             locate_q, locate_d;
  logic             rd_valid_q, rd_valid_d;
  logic             pend_valid_q, pend_valid_d;
  logic             res_valid_q, res_valid_d;

  // payload
  logic [DATA_W-1:0] key_q, key_d;
  logic [POS_W-1:0]  rd_pos_q, rd_pos_d;
  logic              rd_last_q, rd_last_d;
  logic [POS_W-1:0]  pend_pos_q, pend_pos_d;
  logic [DATA_W-1:0] pend_val_q, pend_val_d;
  res_t              res_q, res_d;

  // entry memory, one write or one read a cycle
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata;

  logic full, empty;
  assign full  = (count_q >= OCC_W'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    k_d          = k_q;
    locate_d     = locate_q;
    key_d        = key_q;
    rd_valid_d   = 1'b0;
    rd_pos_d     = rd_pos_q;
    rd_last_d    = rd_last_q;
    pend_valid_d = pend_valid_q;
    pend_pos_d   = pend_pos_q;
    pend_val_d   = pend_val_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    we           = 1'b0;
    waddr        = '0;
    wdata        = '0;
    re           = 1'b0;
    raddr        = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (req_i.cmd)
            CMD_INSERT: begin
              if (full) begin
                res_valid_d = 1'b1;
                res_d = mk_res(ST_FULL, '0, '0, count_q, 1'b1);
              end else if (req_i.value != '0) begin
                // a zero value is never stored
                we          = 1'b1;
                waddr       = slot_of(head_q, count_q);
                wdata       = req_i.value;
                count_d     = count_q + OCC_W'(1);
                res_valid_d = 1'b1;
                res_d = mk_res(ST_DONE, '0, '0, count_d, 1'b1);
              end
            end
            CMD_REMOVE: begin
              res_valid_d = 1'b1;
              if (empty) begin
                res_d = mk_res(ST_EMPTY, '0, '0, count_q, 1'b1);
              end else begin
                head_d  = slot_of(head_q, OCC_W'(1));
                count_d = count_q - OCC_W'(1);
                res_d   = mk_res(ST_DONE, '0, '0, count_d, 1'b1);
              end
            end
            CMD_DISPLAY: begin
              if (empty) begin
                res_valid_d = 1'b1;
                res_d = mk_res(ST_EMPTY, '0, '0, count_q, 1'b1);
              end else begin
                locate_d = 1'b0;
                k_d      = '0;
                state_d  = S_SCAN;
              end
            end
            CMD_STATUS: begin
              res_valid_d = 1'b1;
              res_d = mk_res(ST_DONE, '0, '0, count_q, 1'b1);
            end
            CMD_LOCATE: begin
              if (empty) begin
                res_valid_d = 1'b1;
                res_d = mk_res(ST_NOTFOUND, '0, '0, count_q, 1'b1);
              end else begin
                locate_d     = 1'b1;
                key_d        = req_i.value;
                pend_valid_d = 1'b0;
                k_d          = '0;
                state_d      = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        re         = 1'b1;
        raddr      = slot_of(head_q, k_q);
        rd_valid_d = 1'b1;
        rd_pos_d   = k_q[POS_W-1:0];
        rd_last_d  = ((k_q + OCC_W'(1)) == count_q);
        k_d        = k_q + OCC_W'(1);
        if (rd_last_d) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = locate_q ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        res_valid_d = 1'b1;
        if (pend_valid_q) begin
          res_d = mk_res(ST_ENTRY, pend_pos_q, pend_val_q, count_q, 1'b1);
        end else begin
          res_d = mk_res(ST_NOTFOUND, '0, '0, count_q, 1'b1);
        end
        pend_valid_d = 1'b0;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // read data stage, active in scan and drain only
    if (rd_valid_q) begin
      if (!locate_q) begin
        res_valid_d = 1'b1;
        res_d = mk_res(ST_ENTRY, rd_pos_q, rdata_q, count_q, rd_last_q);
      end else if (rdata_q == key_q) begin
        // hold the newest match back; the earlier one goes out now
        if (pend_valid_q) begin
          res_valid_d = 1'b1;
          res_d = mk_res(ST_ENTRY, pend_pos_q, pend_val_q, count_q, 1'b0);
        end
        pend_valid_d = 1'b1;
        pend_pos_d   = rd_pos_q;
        pend_val_d   = rdata_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      k_q          <= '0;
      locate_q     <= 1'b0;
      rd_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      k_q          <= k_d;
      locate_q     <= locate_d;
      rd_valid_q   <= rd_valid_d;
      pend_valid_q <= pend_valid_d;
      res_valid_q  <= res_valid_d;
      res_q        <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    rd_pos_q   <= rd_pos_d;
    rd_last_q  <= rd_last_d;
    pend_pos_q <= pend_pos_d;
    pend_val_q <= pend_val_d;
  end

  // writes only happen in idle and reads only during a walk, so a read
  // never meets a write to the same slot
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/fqs_checker.sv
// fqs_checker: port-level assertions for the fifo queue with search core
// depends on fqs_pkg; bound to fifo_queue_with_search_core below
module fqs_checker
  import fqs_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic res_valid_o,
  input res_t res_o
);

  // occupancy never exceeds the queue depth
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.occupancy <= OCC_W'(DEPTH)))
    else $error("occupancy above depth");

  // a reported entry lies inside the stored range
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == ST_ENTRY) |->
      ({1'b0, res_o.position} < res_o.occupancy))
    else $error("entry position beyond occupancy");

  // status command answers in the next cycle with a single final word
  a_status_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.cmd == CMD_STATUS) |=>
      (res_valid_o && res_o.status == ST_DONE && res_o.last))
    else $error("status command not answered");

  // more words of the same command follow, so the block is still walking
  a_nonlast_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |-> busy)
    else $error("non-final result while idle");

endmodule

bind fifo_queue_with_search_core fqs_checker #(.DEPTH(DEPTH)) u_fqs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_i       (req_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

>>> tb/sv/fifo_queue_with_search_core_test.sv
// fifo_queue_with_search_core_test: self-checking bench for the fifo queue with search core,
// with a queue predictor in a small scoreboard class and random command traffic
// depends on fqs_pkg and fifo_queue_with_search_core
module fifo_queue_with_search_core_test;
  import fqs_pkg::*;

  localparam int unsigned DEPTH = 64;

  // command codes above locate are spare, the core drops them
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_LOCATE + 3'd1;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  // percent chance that the idle gap after a command goes on
  localparam int unsigned IDLE_PCT    = 26;
  localparam int unsigned RANDOM_WORDS = 180;

  // queue predictor plus the list of result words still owed by the core
  class fqs_scoreboard;
    logic signed [DATA_W-1:0] slots [DEPTH];
    int unsigned head;
    int unsigned count;
    int unsigned errors;
    res_t owed_q [$];

    function new();
      head   = 0;
      count  = 0;
      errors = 0;
    endfunction

    function int unsigned slot_at(int unsigned k);
      return (head + k) % DEPTH;
    endfunction

    // occupancy is taken after the command has updated the queue
    function void owe(logic [STAT_W-1:0] st, int unsigned pos, logic signed [DATA_W-1:0] v);
      res_t r;
      r.status      = st;
      r.position    = pos[POS_W-1:0];
      r.entry_value = v;
      r.occupancy   = count[OCC_W-1:0];
      r.last        = 1'b0;
      owed_q.push_back(r);
    endfunction

    // called for every command word the core takes
    function void note_command(req_t w);
      int unsigned owed_before;
      res_t tail;
      owed_before = owed_q.size();
      case (w.cmd)
        CMD_INSERT: begin
          if (count >= DEPTH) begin
            owe(ST_FULL, 0, '0);
          end else if (w.value == 0) begin
            return;
          end else begin
            slots[slot_at(count)] = w.value;
            count++;
            owe(ST_DONE, 0, '0);
          end
        end
        CMD_REMOVE: begin
          if (count == 0) begin
            owe(ST_EMPTY, 0, '0);
          end else begin
            head = slot_at(1);
            count--;
            owe(ST_DONE, 0, '0);
          end
        end
        CMD_DISPLAY: begin
          if (count == 0) begin
            owe(ST_EMPTY, 0, '0);
          end else begin
            for (int unsigned k = 0; k < count; k++) owe(ST_ENTRY, k, slots[slot_at(k)]);
          end
        end
        CMD_STATUS: owe(ST_DONE, 0, '0);
        CMD_LOCATE: begin
          for (int unsigned k = 0; k < count; k++) begin
            if (slots[slot_at(k)] == w.value) owe(ST_ENTRY, k, w.value);
          end
          if (owed_q.size() == owed_before) owe(ST_NOTFOUND, 0, '0);
        end
        default: return;
      endcase
      // the final word of the command carries last
      tail = owed_q.pop_back();
      tail.last = 1'b1;
      owed_q.push_back(tail);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_result(res_t got);
      res_t want;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing owed, status %0d pos %0d",
                                  got.status, got.position));
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.position !== want.position)
        report_mismatch($sformatf("position %0d, want %0d", got.position, want.position));
      if (got.entry_value !== want.entry_value)
        report_mismatch($sformatf("entry_value %0d, want %0d",
                                  got.entry_value, want.entry_value));
      if (got.occupancy !== want.occupancy)
        report_mismatch($sformatf("occupancy %0d, want %0d", got.occupancy, want.occupancy));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    endtask

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  res_t res_o;

  fqs_scoreboard sb = new();

  // idle gaps are switched off over one long stretch of the random part
  bit quiet;

  // values that repeat often, so locate finds several matches, plus the extremes
  logic signed [DATA_W-1:0] hot_values [8] = '{
    32'sd1, -32'sd1, 32'sd2, 32'sd7, 32'sd100,
    32'sh8000_0000, 32'sh7fff_ffff, 32'sh5555_5555
  };

  always #1 clk_i = ~clk_i;

  fifo_queue_with_search_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // monitor: everything is sampled at the rising edge, before the core's own
  // updates land, so a word counts exactly when the core takes it
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) sb.check_result(res_o);
      if (start && !busy) sb.note_command(req_i);
    end
  end

  // start low with fresh junk on the command bus while idling
  task automatic idle_gap();
    req_t junk;
    while ($urandom_range(0, 99) < IDLE_PCT) begin
      junk.cmd   = CMD_W'($urandom);
      junk.value = $urandom;
      start <= 1'b0;
      req_i <= junk;
      @(posedge clk_i);
    end
  endtask

  // hold the command word until the core takes it, then maybe go idle
  task automatic issue(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val);
    req_t w;
    w.cmd   = cmd;
    w.value = val;
    start <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (!quiet) idle_gap();
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return hot_values[$urandom_range(0, 7)];
      5, 6, 7:       return $urandom_range(1, 100);
      default:       return $urandom;
    endcase
  endfunction

  // command mix per stretch of the random part: mixed, filling, mixed,
  // draining; flags spare codes and inserts of zero in the mixed part as dropped
  task automatic random_word(int unsigned idx, output bit dropped);
    int unsigned roll;
    logic signed [DATA_W-1:0] v;
    roll    = $urandom_range(0, 99);
    v       = pick_value();
    dropped = 1'b0;
    if (idx >= 30 && idx < 100) begin
      // fill: mostly inserts until the queue is full, then poke the full queue
      if (sb.count < DEPTH && roll < 90) begin
        issue(CMD_INSERT, v);
      end else if (roll < 40) begin
        issue(CMD_INSERT, (roll < 10) ? '0 : v);
      end else if (roll < 60) begin
        issue(CMD_DISPLAY, v);
      end else if (roll < 85) begin
        issue(CMD_LOCATE, v);
      end else begin
        issue(CMD_STATUS, v);
      end
    end else if (idx >= 140 && idx < 180) begin
      // drain: mostly removes, sometimes past empty
      if (roll < 70) begin
        issue(CMD_REMOVE, v);
      end else if (roll < 80) begin
        issue(CMD_INSERT, v);
      end else if (roll < 90) begin
        issue(CMD_LOCATE, v);
      end else begin
        issue(CMD_DISPLAY, v);
      end
    end else begin
      if (roll < 3) begin
        // insert of zero is dropped unless the queue is full
        issue(CMD_INSERT, '0);
        dropped = 1'b1;
      end else if (roll < 6) begin
        issue(CMD_LOCATE + CMD_W'($urandom_range(1, 3)), v);
        dropped = 1'b1;
      end else if (roll < 36) begin
        issue(CMD_INSERT, v);
      end else if (roll < 56) begin
        issue(CMD_REMOVE, v);
      end else if (roll < 68) begin
        issue(CMD_DISPLAY, v);
      end else if (roll < 76) begin
        issue(CMD_STATUS, v);
      end else begin
        issue(CMD_LOCATE, (roll < 79) ? '0 : v);
      end
    end
  endtask

  initial begin
    int unsigned counted;
    bit dropped;
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    quiet  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: everything on an empty queue first
    issue(CMD_STATUS, 32'sd9);
    issue(CMD_REMOVE, '0);
    issue(CMD_DISPLAY, '0);
    issue(CMD_LOCATE, '0);
    issue(CMD_INSERT, '0);
    // extremes of the value field and a duplicate
    issue(CMD_INSERT, 32'sh8000_0000);
    issue(CMD_INSERT, 32'sh7fff_ffff);
    issue(CMD_INSERT, -32'sd1);
    issue(CMD_INSERT, 32'sd1);
    issue(CMD_INSERT, 32'sd5);
    issue(CMD_INSERT, 32'sd5);
    issue(CMD_DISPLAY, 32'sd3);
    issue(CMD_LOCATE, 32'sd5);
    issue(CMD_LOCATE, 32'sh8000_0000);
    // a zero key never matches, nor does an absent one
    issue(CMD_LOCATE, '0);
    issue(CMD_LOCATE, 32'sd42);
    // spare codes change nothing
    for (logic [CMD_W:0] c = {1'b0, CMD_SPARE_FIRST}; c <= {1'b0, CMD_SPARE_LAST}; c++)
      issue(c[CMD_W-1:0], 32'sd5);
    issue(CMD_REMOVE, 32'sd1);
    issue(CMD_DISPLAY, '0);
    issue(CMD_STATUS, '0);

    // random part; dropped words do not count toward its length
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      quiet = (counted >= 110 && counted < 160);
      random_word(counted, dropped);
      if (!dropped) counted++;
    end
    start <= 1'b0;

    // drain owed words, then let a full-depth walk's worth of cycles pass
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
